// ===== hw/rtl/tshl_pkg.sv =====
`default_nettype none
package tshl_pkg;

	localparam int COORD_W     = 32;
	localparam int SLOT_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int ROW_W       = 10 * COORD_W;
	localparam int IN_TDATA_W  = 328;
	localparam int OUT_TDATA_W = 40;
	localparam int DIV_STEPS   = 33;
	localparam int DIV_CNT_W   = 6;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Word positions inside one stored triangle row.
	localparam int W_X0 = 0;
	localparam int W_Z0 = 1;
	localparam int W_X1 = 2;
	localparam int W_Z1 = 3;
	localparam int W_X2 = 4;
	localparam int W_Z2 = 5;
	localparam int W_Y0 = 6;
	localparam int W_NX = 7;
	localparam int W_NY = 8;
	localparam int W_NZ = 9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN_HIT,
		ST_FIN_MISS
	} state_t;

	typedef struct packed {
		logic load;
		logic query_start;
		logic issue;
		logic flush;
		logic capture;
		logic mul;
		logic prep;
		logic step;
		logic fin_hit;
		logic fin_miss;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic hit;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tshl_ctrl.sv =====
`default_nettype none
module tshl_ctrl
	import tshl_pkg::*;
#(
	parameter int MAX_TRIANGLES = 64,
	parameter int IDX_W = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	input  wire logic               in_op,
	output logic                    in_ready,
	input  sts_t                    sts,
	output cmd_t                    cmd,
	output logic [IDX_W-1:0]        rd_addr
);

	localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   count_q;
	logic [CNT_W-1:0]     scan_q;
	logic [DIV_CNT_W-1:0] div_q;
	logic [CMP_W-1:0]     limit;
	logic                 scan_done;

	// The scan never runs past the table's capacity.
	assign limit = (CMP_W'(count_q) > CMP_W'(MAX_TRIANGLES)) ?
		CMP_W'(MAX_TRIANGLES) : CMP_W'(count_q);
	assign scan_done = (CMP_W'(scan_q) >= limit);
	assign rd_addr   = scan_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			div_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.query_start) begin
				scan_q <= '0;
			end else if (cmd.issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmd.prep) begin
				div_q <= '0;
			end else if (cmd.step) begin
				div_q <= div_q + DIV_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					state_d = ST_MUL;
				end else if (scan_done && !sts.busy) begin
					state_d = ST_FIN_MISS;
				end
			end
			ST_MUL:  state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (div_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN_HIT;
				end
			end
			ST_FIN_HIT, ST_FIN_MISS: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.load        = in_valid && in_op == OP_LOAD;
				cmd.query_start = in_valid && in_op == OP_QUERY;
			end
			ST_SCAN: begin
				cmd.issue   = !scan_done && !sts.hit;
				cmd.capture = sts.hit;
				cmd.flush   = sts.hit;
			end
			ST_MUL:      cmd.mul      = 1'b1;
			ST_PREP:     cmd.prep     = 1'b1;
			ST_DIV:      cmd.step     = 1'b1;
			ST_FIN_HIT:  cmd.fin_hit  = sts.out_free;
			ST_FIN_MISS: cmd.fin_miss = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tshl_dpath.sv =====
`default_nettype none
module tshl_dpath
	import tshl_pkg::*;
#(
	parameter int MAX_TRIANGLES = 64,
	parameter int IDX_W = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [IN_TDATA_W-1:0]  in_data,
	input  cmd_t                        cmd,
	input  wire logic [IDX_W-1:0]       rd_addr,
	output sts_t                        sts,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        out_found,
	output logic [OUT_TDATA_W-1:0]      out_data
);

	logic [ROW_W-1:0] mem [MAX_TRIANGLES];

	logic [10:0]      slot_ext;
	logic signed [31:0] px_q, pz_q;

	// Scan pipeline
	logic             v_s1, v_s2, v_s3, v_s4;
	logic [ROW_W-1:0] row_s1;
	logic [IDX_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [31:0] ax, az, bx, bz, cx, cz;
	logic signed [32:0] v0x_s2, v0z_s2, v1x_s2, v1z_s2, v2x_s2, v2z_s2;
	logic signed [32:0] v2x_s3, v2z_s3, v2x_s4, v2z_s4;
	logic [127:0]       pl_s2, pl_s3, pl_s4;   // y0, nx, ny, nz
	logic signed [65:0] pd_s3, pd2_s3, pu_s3, pu2_s3, pv_s3, pv2_s3;
	logic signed [66:0] d_s4, u_s4, v_s4x;
	logic signed [67:0] sum_uv;
	logic               hit;

	// Height unit
	logic [IDX_W-1:0]   h_tag_q;
	logic signed [32:0] hx_q, hz_q;
	logic signed [31:0] hy0_q, hnx_q, hny_q, hnz_q;
	logic signed [64:0] pnx_q, pnz_q;
	logic signed [65:0] num;
	logic [65:0]        mag;
	logic [31:0]        dvs, d_q;
	logic               neg_q, ovf_q, nyz_q;
	logic [32:0]        rem_q, low_q, q_q, trial;
	logic signed [34:0] sq, hsum;
	logic signed [31:0] height;

	assign slot_ext = 11'(in_data[SLOT_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load && slot_ext < 11'(MAX_TRIANGLES)) begin
			mem[slot_ext[IDX_W-1:0]] <= in_data[SLOT_W +: ROW_W];
		end
		if (cmd.issue) begin
			row_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && !cmd.flush;
			v_s2 <= v_s1 && !cmd.flush;
			v_s3 <= v_s2 && !cmd.flush;
			v_s4 <= v_s3 && !cmd.flush;
		end
	end

	assign ax = row_s1[W_X0*COORD_W +: COORD_W];
	assign az = row_s1[W_Z0*COORD_W +: COORD_W];
	assign bx = row_s1[W_X1*COORD_W +: COORD_W];
	assign bz = row_s1[W_Z1*COORD_W +: COORD_W];
	assign cx = row_s1[W_X2*COORD_W +: COORD_W];
	assign cz = row_s1[W_Z2*COORD_W +: COORD_W];

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			px_q <= in_data[SLOT_W + W_X0*COORD_W +: COORD_W];
			pz_q <= in_data[SLOT_W + W_Z0*COORD_W +: COORD_W];
		end
		if (cmd.issue) begin
			tag_s1 <= rd_addr;
		end
		// Edge vectors from corner A and the point's offset from A.
		v0x_s2 <= 33'(cx) - 33'(ax);
		v0z_s2 <= 33'(cz) - 33'(az);
		v1x_s2 <= 33'(bx) - 33'(ax);
		v1z_s2 <= 33'(bz) - 33'(az);
		v2x_s2 <= 33'(px_q) - 33'(ax);
		v2z_s2 <= 33'(pz_q) - 33'(az);
		pl_s2  <= row_s1[W_Y0*COORD_W +: 4*COORD_W];
		tag_s2 <= tag_s1;
		// Cross product terms.
		pd_s3  <= v0x_s2 * v1z_s2;
		pd2_s3 <= v0z_s2 * v1x_s2;
		pu_s3  <= v2x_s2 * v1z_s2;
		pu2_s3 <= v2z_s2 * v1x_s2;
		pv_s3  <= v0x_s2 * v2z_s2;
		pv2_s3 <= v0z_s2 * v2x_s2;
		v2x_s3 <= v2x_s2;
		v2z_s3 <= v2z_s2;
		pl_s3  <= pl_s2;
		tag_s3 <= tag_s2;
		d_s4   <= 67'(pd_s3) - 67'(pd2_s3);
		u_s4   <= 67'(pu_s3) - 67'(pu2_s3);
		v_s4x  <= 67'(pv_s3) - 67'(pv2_s3);
		v2x_s4 <= v2x_s3;
		v2z_s4 <= v2z_s3;
		pl_s4  <= pl_s3;
		tag_s4 <= tag_s3;
	end

	// With a negative determinant every sign of the test flips.
	assign sum_uv = 68'(u_s4) + 68'(v_s4x);
	always_comb begin
		if (d_s4 > 67'sd0) begin
			hit = (u_s4 >= 67'sd0) && (v_s4x >= 67'sd0) && (sum_uv < 68'(d_s4));
		end else if (d_s4 < 67'sd0) begin
			hit = (u_s4 <= 67'sd0) && (v_s4x <= 67'sd0) && (sum_uv > 68'(d_s4));
		end else begin
			hit = 1'b0;
		end
	end

	assign sts.hit  = v_s4 && hit;
	assign sts.busy = v_s1 || v_s2 || v_s3 || v_s4;

	// Height: y0 + ((ax - px)*nx + (az - pz)*nz) / ny.
	assign num   = 66'(pnx_q) + 66'(pnz_q);
	assign mag   = num[65] ? 66'(-num) : 66'(num);
	assign dvs   = hny_q[31] ? 32'(-33'(hny_q)) : 32'(hny_q);
	assign trial = {rem_q[31:0], low_q[32]};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			h_tag_q <= tag_s4;
			hx_q    <= -v2x_s4;
			hz_q    <= -v2z_s4;
			hy0_q   <= pl_s4[0*COORD_W +: COORD_W];
			hnx_q   <= pl_s4[1*COORD_W +: COORD_W];
			hny_q   <= pl_s4[2*COORD_W +: COORD_W];
			hnz_q   <= pl_s4[3*COORD_W +: COORD_W];
		end
		if (cmd.mul) begin
			pnx_q <= hx_q * hnx_q;
			pnz_q <= hz_q * hnz_q;
		end
		if (cmd.prep) begin
			neg_q <= num[65] ^ hny_q[31];
			nyz_q <= (hny_q == 32'sd0);
			d_q   <= dvs;
			ovf_q <= (mag[65:33] >= {1'b0, dvs});
			rem_q <= mag[65:33];
			low_q <= mag[32:0];
			q_q   <= '0;
		end else if (cmd.step) begin
			if (trial >= {1'b0, d_q}) begin
				rem_q <= trial - {1'b0, d_q};
				q_q   <= {q_q[31:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[31:0], 1'b0};
			end
			low_q <= {low_q[31:0], 1'b0};
		end
	end

	assign sq   = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
	assign hsum = sq + 35'(hy0_q);

	always_comb begin
		if (nyz_q) begin
			height = hy0_q;
		end else if (ovf_q) begin
			height = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (hsum > 35'sh0_7fff_ffff) begin
			height = 32'sh7fff_ffff;
		end else if (hsum < -35'sh0_8000_0000) begin
			height = 32'sh8000_0000;
		end else begin
			height = 32'(hsum);
		end
	end

	assign sts.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.fin_hit || cmd.fin_miss) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_hit) begin
			out_found <= 1'b1;
			out_data  <= {2'b00, height, SLOT_W'(h_tag_q)};
		end else if (cmd.fin_miss) begin
			out_found <= 1'b0;
			out_data  <= '0;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_surface_height_lookup.sv =====
// Load items write one table row; the next item may follow directly.
// A query scans one slot per cycle until a slot matches or the count is reached; on a hit
// the height comes from the 33-step serial divider. The result is registered once the
// output register is free.
// One item is in work at a time; a finished result waits in the output register.
// Reset (arst_n, asynchronous, active low) clears the count register and all control state.
`default_nettype none
module triangle_surface_height_lookup
	import tshl_pkg::*;
#(
	parameter int MAX_TRIANGLES = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Count register write port.
	input  wire logic                   cfg_we,
	input  wire logic [COUNT_W-1:0]     cfg_wdata,
	// Input items.
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// slot[5:0], x0, z0, x1, z1, x2, z2, y0, nx, ny, nz (32 bits each), 2 pad bits
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  wire logic                   s_axis_tuser,
	// Result items.
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// tri_index[5:0], height[37:6], 2 pad bits
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// found
	output logic                        m_axis_tuser
);

	// The triangle table holds no reset value and must be loaded before it is scanned.
	localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] rd_addr;

	// The controller walks the slots and sequences the height unit; the
	// datapath holds the table, the four-stage containment pipeline and the divider.
	tshl_ctrl #(
		.MAX_TRIANGLES(MAX_TRIANGLES),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid),
		.in_op(s_axis_tuser),
		.in_ready(s_axis_tready),
		.sts(sts),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	tshl_dpath #(
		.MAX_TRIANGLES(MAX_TRIANGLES),
		.IDX_W(IDX_W)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(s_axis_tdata),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.sts(sts),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_found(m_axis_tuser),
		.out_data(m_axis_tdata)
	);

endmodule
`default_nettype wire
